### hdl/chained_hash_table_core_defines.svh
// Assertion helpers shared by the hash table RTL.
// Each expects clk and arst_n in the enclosing module.
`ifndef CHAINED_HASH_TABLE_CORE_DEFINES_SVH
`define CHAINED_HASH_TABLE_CORE_DEFINES_SVH

// Holds at every clock edge out of reset.
`define CHT_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// When ante holds, cons holds in the next cycle.
`define CHT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/cht_pkg.sv
package cht_pkg;

	localparam int BUCKET_COUNT = 5;
	localparam int POOL_SLOTS   = 64;
	localparam int PAYLOAD_BITS = 64;

	localparam int KEY_W   = 31;
	localparam int PAY_W   = 64;
	localparam int SLOT_W  = $clog2(POOL_SLOTS);
	localparam int CNT_W   = $clog2(POOL_SLOTS + 1);
	localparam int BKT_W   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam int REM_W   = $clog2(2 * BUCKET_COUNT);
	localparam int ENTRY_W = KEY_W + PAYLOAD_BITS;

	// key mod BUCKET_COUNT by reciprocal: q_est = (key * RECIP) >> KEY_W is q or q - 1
	localparam int RECIP_W = 32;
	localparam int PROD_W  = KEY_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << KEY_W) / BUCKET_COUNT);

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_FOUND    = 2'd2;
	localparam logic [1:0] ST_MISSING  = 2'd3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FIND   = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} cht_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [PAY_W-1:0] found_payload;
	} cht_rsp_t;

	typedef struct packed {
		logic       load;
		logic       hash_mul;
		logic       hash_sub;
		logic       hash_fix;
		logic       insert;
		logic       read_head;
		logic       walk_next;
		logic       emit;
		logic [1:0] status;
	} cht_cmd_t;

	typedef struct packed {
		logic is_find;
		logic pool_full;
		logic bkt_valid;
		logic key_match;
		logic at_tail;
	} cht_stat_t;

endpackage

### hdl/cht_ram.sv
module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hdl/cht_datapath.sv
`include "chained_hash_table_core_defines.svh"

module cht_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  cht_pkg::cht_req_t request,
	input  cht_pkg::cht_cmd_t cmd,
	output cht_pkg::cht_stat_t stat,
	output logic              done,
	output cht_pkg::cht_rsp_t result
);

	cht_pkg::cht_req_t                req_q;
	logic [cht_pkg::PROD_W-1:0]       prod_q;
	logic [cht_pkg::REM_W-1:0]        rem_q;
	logic [cht_pkg::BKT_W-1:0]        bucket_q;
	logic [cht_pkg::BUCKET_COUNT-1:0] head_valid_q;
	logic [cht_pkg::SLOT_W-1:0]       head_q [cht_pkg::BUCKET_COUNT];
	logic [cht_pkg::SLOT_W-1:0]       tail_q [cht_pkg::BUCKET_COUNT];
	logic [cht_pkg::CNT_W-1:0]        used_q;
	logic [cht_pkg::SLOT_W-1:0]       cur_q;
	logic                             done_q;
	cht_pkg::cht_rsp_t                rsp_q;

	logic [cht_pkg::KEY_W-1:0]        quot;
	logic [cht_pkg::KEY_W-1:0]        rem_full;
	logic [cht_pkg::SLOT_W-1:0]       new_slot;
	logic [cht_pkg::SLOT_W-1:0]       rd_addr;
	logic [cht_pkg::SLOT_W-1:0]       link_rd;
	logic [cht_pkg::ENTRY_W-1:0]      entry_rd;
	logic [cht_pkg::PAYLOAD_BITS-1:0] rd_payload;
	logic                             link_we;

	assign quot     = prod_q[2*cht_pkg::KEY_W-1:cht_pkg::KEY_W];
	assign rem_full = req_q.key
		- cht_pkg::KEY_W'(quot * cht_pkg::KEY_W'(cht_pkg::BUCKET_COUNT));
	assign new_slot = used_q[cht_pkg::SLOT_W-1:0];

	// walk follows the link just read; otherwise start at the bucket head
	assign rd_addr    = cmd.walk_next ? link_rd : head_q[bucket_q];
	assign rd_payload = entry_rd[cht_pkg::PAYLOAD_BITS-1:0];
	assign link_we    = cmd.insert && head_valid_q[bucket_q];

	assign stat.is_find   = (req_q.operation == cht_pkg::OP_FIND);
	assign stat.pool_full = (used_q == cht_pkg::CNT_W'(cht_pkg::POOL_SLOTS));
	assign stat.bkt_valid = head_valid_q[bucket_q];
	assign stat.key_match =
		(entry_rd[cht_pkg::ENTRY_W-1:cht_pkg::PAYLOAD_BITS] == req_q.key);
	assign stat.at_tail   = (cur_q == tail_q[bucket_q]);

	cht_ram #(
		.WIDTH(cht_pkg::ENTRY_W),
		.DEPTH(cht_pkg::POOL_SLOTS)
	) u_entry_ram (
		.clk  (clk),
		.we   (cmd.insert),
		.waddr(new_slot),
		.wdata({req_q.key, req_q.payload[cht_pkg::PAYLOAD_BITS-1:0]}),
		.raddr(rd_addr),
		.rdata(entry_rd)
	);

	// chain end is the bucket tail, so only the forward link is stored
	cht_ram #(
		.WIDTH(cht_pkg::SLOT_W),
		.DEPTH(cht_pkg::POOL_SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(tail_q[bucket_q]),
		.wdata(new_slot),
		.raddr(rd_addr),
		.rdata(link_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= '0;
			used_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.insert) begin
				used_q                 <= used_q + 1'b1;
				head_valid_q[bucket_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= request;
		end
		if (cmd.hash_mul) begin
			prod_q <= cht_pkg::PROD_W'(req_q.key) * cht_pkg::PROD_W'(cht_pkg::RECIP);
		end
		if (cmd.hash_sub) begin
			rem_q <= rem_full[cht_pkg::REM_W-1:0];
		end
		if (cmd.hash_fix) begin
			if (rem_q >= cht_pkg::REM_W'(cht_pkg::BUCKET_COUNT)) begin
				bucket_q <= cht_pkg::BKT_W'(rem_q - cht_pkg::REM_W'(cht_pkg::BUCKET_COUNT));
			end else begin
				bucket_q <= cht_pkg::BKT_W'(rem_q);
			end
		end
		if (cmd.insert) begin
			tail_q[bucket_q] <= new_slot;
			if (!head_valid_q[bucket_q]) begin
				head_q[bucket_q] <= new_slot;
			end
		end
		if (cmd.read_head || cmd.walk_next) begin
			cur_q <= rd_addr;
		end
		if (cmd.emit) begin
			rsp_q.status <= cmd.status;
			if (cmd.status == cht_pkg::ST_FOUND) begin
				rsp_q.found_payload <= cht_pkg::PAY_W'(rd_payload);
			end else begin
				rsp_q.found_payload <= '0;
			end
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

	`CHT_CHECK(a_used_bound, used_q <= cht_pkg::CNT_W'(cht_pkg::POOL_SLOTS), "slot count overrun")
	`CHT_CHECK(a_no_insert_full, !(cmd.insert && stat.pool_full), "insert into full pool")
	`CHT_IMPLY(a_used_step, cmd.insert, used_q == cht_pkg::CNT_W'($past(used_q) + 1'b1), "slot count did not advance")
	`CHT_CHECK(a_zero_payload, !done_q || rsp_q.status == cht_pkg::ST_FOUND || rsp_q.found_payload == '0, "payload not zero on miss")

endmodule

### hdl/cht_ctrl.sv
`include "chained_hash_table_core_defines.svh"

module cht_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cht_pkg::cht_stat_t stat,
	output cht_pkg::cht_cmd_t  cmd,
	output logic               busy
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_HASH1    = 3'd1;
	localparam logic [2:0] S_HASH2    = 3'd2;
	localparam logic [2:0] S_HASH3    = 3'd3;
	localparam logic [2:0] S_DISPATCH = 3'd4;
	localparam logic [2:0] S_CHECK    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_HASH1;
				end
			end
			S_HASH1: begin
				cmd.hash_mul = 1'b1;
				state_nxt    = S_HASH2;
			end
			S_HASH2: begin
				cmd.hash_sub = 1'b1;
				state_nxt    = S_HASH3;
			end
			S_HASH3: begin
				cmd.hash_fix = 1'b1;
				state_nxt    = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (!stat.is_find) begin
					cmd.emit   = 1'b1;
					cmd.insert = !stat.pool_full;
					cmd.status = stat.pool_full ? cht_pkg::ST_FULL : cht_pkg::ST_INSERTED;
					state_nxt  = S_IDLE;
				end else if (!stat.bkt_valid) begin
					cmd.emit   = 1'b1;
					cmd.status = cht_pkg::ST_MISSING;
					state_nxt  = S_IDLE;
				end else begin
					cmd.read_head = 1'b1;
					state_nxt     = S_CHECK;
				end
			end
			S_CHECK: begin
				// slot data for cur is on the RAM outputs this cycle
				if (stat.key_match) begin
					cmd.emit   = 1'b1;
					cmd.status = cht_pkg::ST_FOUND;
					state_nxt  = S_IDLE;
				end else if (stat.at_tail) begin
					cmd.emit   = 1'b1;
					cmd.status = cht_pkg::ST_MISSING;
					state_nxt  = S_IDLE;
				end else begin
					cmd.walk_next = 1'b1;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

	`CHT_IMPLY(a_emit_idle, cmd.emit, state_q == S_IDLE, "not idle after result")
	`CHT_IMPLY(a_accept_hash, start && !busy, state_q == S_HASH1, "request not taken")
	`CHT_CHECK(a_walk_excl, !(cmd.walk_next && cmd.emit), "walk and result together")

endmodule

### hdl/chained_hash_table_core.sv
// Hash table with separate chaining over a 64-slot pool; bucket = key mod 5.
// A request is taken when start is high and busy is low. Every request yields
// exactly one result, shown for a single cycle with done high; the receiver
// cannot stall it, so it must take the result in that cycle. An insert, a
// dropped insert on a full pool, and a find on an empty bucket stay busy for the
// reciprocal-multiply modulo (multiply, subtract, fix) and a dispatch step that
// updates the bucket registers on an insert. A find then walks the bucket chain
// one slot per cycle through the registered read of the slot memories, stopping
// at the first matching entry or at the tail of the chain. The result appears in
// the first cycle with busy low, and a new request may be given in that same
// cycle. Slots are never freed; duplicate keys are allowed and a find returns
// the earliest inserted one.
module chained_hash_table_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cht_pkg::cht_req_t request,
	output logic              done,
	output cht_pkg::cht_rsp_t result
);

	cht_pkg::cht_cmd_t  cmd;
	cht_pkg::cht_stat_t stat;

	cht_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	cht_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

endmodule
